FILE: src/lsclcg_pkg.sv
// ----------------------------------------------------------------------------
// lsclcg_pkg: shared types and constants of the list shuffle unit
// Field widths, generator constants, operation codes, controller states and
// the command and status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package lsclcg_pkg;

  // Store geometry and shuffle passes
  localparam int LIST_DEPTH = 1024;
  localparam int PASSES     = 3;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int PASS_W     = (PASSES > 1) ? $clog2(PASSES) : 1;

  // Item field widths
  localparam int OP_W    = 2;
  localparam int INDEX_W = 10;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 11;
  localparam int SEED_W  = 31;

  // Stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 40;

  // Generator arithmetic widths
  localparam int MULT_W   = 16;
  localparam int FOLD_W   = 8;
  localparam int PROD_W   = SEED_W + MULT_W;
  localparam int HI_SC_W  = MULT_W + FOLD_W;
  localparam int SCALE_W  = SEED_W + COUNT_W;
  localparam int Q_SC_W   = COUNT_W + FOLD_W;

  // Generator constants; FOLD is 2^31 minus the modulus
  localparam logic [SEED_W-1:0] MOD_A        = 31'd2147483563;
  localparam logic [SEED_W-1:0] MOD_B        = 31'd2147483399;
  localparam logic [SEED_W-1:0] WRAP_ADD     = 31'd2147483562;
  localparam logic [SEED_W-1:0] SEED_A_RESET = 31'd12345;
  localparam logic [SEED_W-1:0] SEED_B_RESET = 31'd67890;
  localparam logic [MULT_W-1:0] MUL_A        = 16'd40014;
  localparam logic [MULT_W-1:0] MUL_B        = 16'd40692;
  localparam logic [FOLD_W-1:0] FOLD_A       = 8'd85;
  localparam logic [FOLD_W-1:0] FOLD_B       = 8'd249;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_SHUFFLE = 2'd1,
    OP_READ    = 2'd2
  } op_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_SEED_A = 1'b0,
    CFG_SEED_B = 1'b1
  } cfg_reg_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_RED,
    ST_ZED,
    ST_SCL,
    ST_QUO,
    ST_RDJ,
    ST_WRP,
    ST_WRJ,
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic start_shuf;   // capture count, clear step counters
    logic gen_mul;      // register generator products
    logic gen_red;      // reduce products into generator state
    logic z_ld;         // register combined output
    logic scl_ld;       // register z times count
    logic j_ld;         // register swap partner index
    logic rd_idx;       // read store at item index
    logic rd_pos;       // read store at step position
    logic rd_j;         // read store at partner index
    logic wr_in;        // write item value at item index
    logic wr_pos;       // write partner word at step position
    logic wr_j;         // write held word at partner index
    logic cap_tmp;      // hold word read from step position
    logic step_adv;     // advance step position and pass
    logic out_ld;       // load result register
    logic out_sel_read; // result data from store read
    logic out_status;   // result status bit
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last_step;
  } sts_t;

endpackage

FILE: src/lsclcg_ram.sv
// ----------------------------------------------------------------------------
// lsclcg_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lsclcg_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rd_data_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/lsclcg_dpath.sv
// ----------------------------------------------------------------------------
// lsclcg_dpath: store, combined generator and swap datapath
// Holds the word store, both generator states, the scaling of the combined
// output to a partner index, step counters and the result register.
// ----------------------------------------------------------------------------
module lsclcg_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lsclcg_pkg::cmd_t             cmd,
  output lsclcg_pkg::sts_t             sts,
  input  logic [lsclcg_pkg::INDEX_W-1:0] in_index,
  input  logic [lsclcg_pkg::WORD_W-1:0]  in_value,
  input  logic [lsclcg_pkg::COUNT_W-1:0] in_count,
  input  logic                         cfg_wr_en,
  input  logic [0:0]                   cfg_index,
  input  logic [lsclcg_pkg::SEED_W-1:0]  cfg_wr_data,
  output logic [lsclcg_pkg::WORD_W-1:0]  out_read_data,
  output logic                         out_status
);

  import lsclcg_pkg::*;

  logic [SEED_W-1:0]  gen_a_r, gen_b_r;
  logic [PROD_W-1:0]  prod_a_r, prod_b_r;
  logic [SEED_W-1:0]  z_r;
  logic [SCALE_W-1:0] scale_r;
  logic [IDX_W-1:0]   j_r;
  logic [COUNT_W-1:0] n_r, pos_r;
  logic [PASS_W-1:0]  pass_r;
  logic [WORD_W-1:0]  tmp_r, out_data_r;
  logic               out_status_r;

  logic [HI_SC_W-1:0] hi_a_sc, hi_b_sc;
  logic [SEED_W:0]    fold_a, fold_b;
  logic [SEED_W-1:0]  red_a, red_b;
  logic [SEED_W+1:0]  diff, zsum;
  logic [SEED_W-1:0]  z_nxt;
  logic [COUNT_W-1:0] q0;
  logic [Q_SC_W-1:0]  q0_sc;
  logic [SEED_W:0]    rem;
  logic [IDX_W-1:0]   j_nxt;
  logic               last_pos, last_pass;

  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [WORD_W-1:0]  ram_wdata, ram_rdata;

  // Fold the high product bits back in (2^31 is FOLD mod M), then one subtract
  always_comb begin
    hi_a_sc = HI_SC_W'(prod_a_r[PROD_W-1:SEED_W]) * HI_SC_W'(FOLD_A);
    hi_b_sc = HI_SC_W'(prod_b_r[PROD_W-1:SEED_W]) * HI_SC_W'(FOLD_B);
    fold_a  = (SEED_W+1)'(prod_a_r[SEED_W-1:0]) + (SEED_W+1)'(hi_a_sc);
    fold_b  = (SEED_W+1)'(prod_b_r[SEED_W-1:0]) + (SEED_W+1)'(hi_b_sc);
    red_a   = (fold_a >= {1'b0, MOD_A}) ? SEED_W'(fold_a - {1'b0, MOD_A})
                                        : fold_a[SEED_W-1:0];
    red_b   = (fold_b >= {1'b0, MOD_B}) ? SEED_W'(fold_b - {1'b0, MOD_B})
                                        : fold_b[SEED_W-1:0];
  end

  // Combine the two generators, wrap results below one
  always_comb begin
    diff = {2'b00, gen_a_r} - {2'b00, gen_b_r};
    zsum = diff + {2'b00, WRAP_ADD};
    if (diff[SEED_W+1] || (diff == '0)) begin
      z_nxt = zsum[SEED_W-1:0];
    end else begin
      z_nxt = diff[SEED_W-1:0];
    end
  end

  // Quotient by MOD_A: estimate from the top bits, correct by one
  always_comb begin
    q0    = scale_r[SCALE_W-1:SEED_W];
    q0_sc = Q_SC_W'(q0) * Q_SC_W'(FOLD_A);
    rem   = (SEED_W+1)'(scale_r[SEED_W-1:0]) + (SEED_W+1)'(q0_sc);
    j_nxt = IDX_W'(q0) + IDX_W'(rem >= {1'b0, MOD_A});
  end

  // Generator state: configuration loads, shuffle steps advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_a_r <= SEED_A_RESET;
      gen_b_r <= SEED_B_RESET;
    end else begin
      if (cfg_wr_en && (cfg_index == CFG_SEED_A)) begin
        gen_a_r <= cfg_wr_data;
      end else if (cmd.gen_red) begin
        gen_a_r <= red_a;
      end
      if (cfg_wr_en && (cfg_index == CFG_SEED_B)) begin
        gen_b_r <= cfg_wr_data;
      end else if (cmd.gen_red) begin
        gen_b_r <= red_b;
      end
    end
  end

  // Arithmetic pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.gen_mul) begin
      prod_a_r <= PROD_W'(gen_a_r) * PROD_W'(MUL_A);
      prod_b_r <= PROD_W'(gen_b_r) * PROD_W'(MUL_B);
    end
    if (cmd.z_ld) begin
      z_r <= z_nxt;
    end
    if (cmd.scl_ld) begin
      scale_r <= SCALE_W'(z_r) * SCALE_W'(n_r);
    end
    if (cmd.j_ld) begin
      j_r <= j_nxt;
    end
    if (cmd.cap_tmp) begin
      tmp_r <= ram_rdata;
    end
  end

  // Step position and pass counters
  assign last_pos  = (pos_r == (n_r - COUNT_W'(1)));
  assign last_pass = (pass_r == PASS_W'(PASSES - 1));
  assign sts.last_step = last_pos && last_pass;

  always_ff @(posedge clk) begin
    if (cmd.start_shuf) begin
      n_r    <= in_count;
      pos_r  <= '0;
      pass_r <= '0;
    end else if (cmd.step_adv) begin
      if (last_pos) begin
        pos_r  <= '0;
        pass_r <= pass_r + PASS_W'(1);
      end else begin
        pos_r <= pos_r + COUNT_W'(1);
      end
    end
  end

  // Store port selection
  always_comb begin
    ram_we    = cmd.wr_in || cmd.wr_pos || cmd.wr_j;
    ram_waddr = j_r;
    ram_wdata = tmp_r;
    priority if (cmd.wr_in) begin
      ram_waddr = IDX_W'(in_index);
      ram_wdata = in_value;
    end else if (cmd.wr_pos) begin
      ram_waddr = pos_r[IDX_W-1:0];
      ram_wdata = ram_rdata;
    end else begin
      ram_waddr = j_r;
      ram_wdata = tmp_r;
    end
  end

  always_comb begin
    ram_re = cmd.rd_idx || cmd.rd_pos || cmd.rd_j;
    priority if (cmd.rd_idx) begin
      ram_raddr = IDX_W'(in_index);
    end else if (cmd.rd_pos) begin
      ram_raddr = pos_r[IDX_W-1:0];
    end else begin
      ram_raddr = j_r;
    end
  end

  lsclcg_ram #(
    .Width (WORD_W),
    .Depth (LIST_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_data_r   <= cmd.out_sel_read ? ram_rdata : '0;
      out_status_r <= cmd.out_status;
    end
  end

  assign out_read_data = out_data_r;
  assign out_status    = out_status_r;

endmodule

FILE: src/lsclcg_ctrl.sv
// ----------------------------------------------------------------------------
// lsclcg_ctrl: operation sequencer
// Decodes accepted items, steps each shuffle swap through generator update,
// index scaling and the four store accesses, and owns the result valid flag.
// ----------------------------------------------------------------------------
module lsclcg_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lsclcg_pkg::OP_W-1:0]    in_op,
  input  logic [lsclcg_pkg::INDEX_W-1:0] in_index,
  input  logic [lsclcg_pkg::COUNT_W-1:0] in_count,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output lsclcg_pkg::cmd_t               cmd,
  input  lsclcg_pkg::sts_t               sts
);

  import lsclcg_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc, idx_ok, cnt_bad, cnt_zero;

  // Item decode
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign idx_ok    = (32'(in_index) < LIST_DEPTH);
  assign cnt_bad   = (32'(in_count) > LIST_DEPTH);
  assign cnt_zero  = (in_count == '0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if ((in_op == OP_READ) && idx_ok) begin
            state_nxt = ST_READ;
          end else if ((in_op == OP_SHUFFLE) && !cnt_bad && !cnt_zero) begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      ST_MUL:  state_nxt = ST_RED;
      ST_RED:  state_nxt = ST_ZED;
      ST_ZED:  state_nxt = ST_SCL;
      ST_SCL:  state_nxt = ST_QUO;
      ST_QUO:  state_nxt = ST_RDJ;
      ST_RDJ:  state_nxt = ST_WRP;
      ST_WRP:  state_nxt = ST_WRJ;
      ST_WRJ:  state_nxt = sts.last_step ? ST_DONE : ST_MUL;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (op_t'(in_op))
            OP_WRITE: begin
              cmd.wr_in      = idx_ok;
              cmd.out_ld     = 1'b1;
              cmd.out_status = !idx_ok;
            end
            OP_SHUFFLE: begin
              cmd.start_shuf = !cnt_bad && !cnt_zero;
              cmd.out_ld     = cnt_bad || cnt_zero;
              cmd.out_status = cnt_bad;
            end
            OP_READ: begin
              cmd.rd_idx     = idx_ok;
              cmd.out_ld     = !idx_ok;
              cmd.out_status = !idx_ok;
            end
            default: begin
              cmd.out_ld     = 1'b1;
              cmd.out_status = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        cmd.out_ld       = 1'b1;
        cmd.out_sel_read = 1'b1;
      end
      ST_MUL: begin
        cmd.gen_mul = 1'b1;
        cmd.rd_pos  = 1'b1;
      end
      ST_RED: begin
        cmd.gen_red = 1'b1;
        cmd.cap_tmp = 1'b1;
      end
      ST_ZED: cmd.z_ld   = 1'b1;
      ST_SCL: cmd.scl_ld = 1'b1;
      ST_QUO: cmd.j_ld   = 1'b1;
      ST_RDJ: cmd.rd_j   = 1'b1;
      ST_WRP: cmd.wr_pos = 1'b1;
      ST_WRJ: begin
        cmd.wr_j     = 1'b1;
        cmd.step_adv = 1'b1;
      end
      ST_DONE: cmd.out_ld = 1'b1;
      default: cmd = '0;
    endcase
  end

  // Result valid: set on load, drop once the transfer completes
  always_comb begin
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

FILE: src/list_shuffle_combined_lcg_unit.sv
// ----------------------------------------------------------------------------
// list_shuffle_combined_lcg_unit: word store with generator-driven shuffle
// Holds 1024 words of 32 bits; writes, reads and in-place shuffles them.
//
// Usage:
//   Input stream in_*: one operation per transfer (write, shuffle, read).
//   Output stream out_*: exactly one result per accepted operation.
//   Configuration cfg_*: index 0 loads the first generator seed, index 1
//   the second; write only while no operation is in progress.
//   Sequence: a write's result is valid in the cycle after acceptance; a read
//   first reads the store, then loads the result. A shuffle of count N runs
//   3*N swap steps (generator multiply with the read at the step position,
//   reduce, combine, scale, quotient, then the partner read and the two
//   swap writes, over one write and one read port) and then loads its result.
//   Rejected and zero-count items answer in the cycle after acceptance.
//   Throughput: one operation at a time; the next is taken once the sequencer is
//   idle and the result register is empty or its result is leaving.
//   Reset loads seeds 12345 and 67890; store contents stay undefined until
//   written, with no clearing pass. A stalled receiver holds the result
//   and blocks further input until it is taken.
// ----------------------------------------------------------------------------
module list_shuffle_combined_lcg_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // op[1:0], index[11:2], value[43:12], count[54:44], zero pad [55]
  input  logic [lsclcg_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // read_data[31:0], status[32], zero pad [39:33]
  output logic [lsclcg_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_wr_en,
  input  logic [0:0]                            cfg_index,
  input  logic [lsclcg_pkg::SEED_W-1:0]         cfg_wr_data
);

  import lsclcg_pkg::*;

  localparam int IDX_LO   = OP_W;
  localparam int VAL_LO   = IDX_LO + INDEX_W;
  localparam int CNT_LO   = VAL_LO + WORD_W;
  localparam int OUT_PAD  = OUT_TDATA_W - WORD_W - 1;

  logic [OP_W-1:0]    in_op;
  logic [INDEX_W-1:0] in_index;
  logic [WORD_W-1:0]  in_value;
  logic [COUNT_W-1:0] in_count;
  logic [WORD_W-1:0]  out_read_data;
  logic               out_status;
  cmd_t               cmd;
  sts_t               sts;

  // Unpack the input item
  assign in_op    = in_tdata[IDX_LO-1:0];
  assign in_index = in_tdata[VAL_LO-1:IDX_LO];
  assign in_value = in_tdata[CNT_LO-1:VAL_LO];
  assign in_count = in_tdata[CNT_LO+COUNT_W-1:CNT_LO];

  lsclcg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_op),
    .in_index   (in_index),
    .in_count   (in_count),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  lsclcg_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_index      (in_index),
    .in_value      (in_value),
    .in_count      (in_count),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wr_data   (cfg_wr_data),
    .out_read_data (out_read_data),
    .out_status    (out_status)
  );

  // Pack the result item
  assign out_tdata = {{OUT_PAD{1'b0}}, out_status, out_read_data};

`ifndef NO_ASSERTIONS
  // A started shuffle must not show a result in the next cycle
  a_shuffle_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_op == OP_SHUFFLE) && (in_count != '0) &&
     (32'(in_count) <= LIST_DEPTH)) |=> !out_tvalid)
    else $error("shuffle result appeared one cycle after acceptance");

  // The result register is loaded only when empty or being drained
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!out_tvalid || out_tready))
    else $error("result register overwritten before transfer");

  // The swap writes come in pairs, position then partner
  a_swap_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_pos |=> cmd.wr_j)
    else $error("swap partner write missing");

  // Generator reduction always follows its multiply
  a_reduce_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gen_red |-> $past(cmd.gen_mul))
    else $error("generator reduced without fresh products");
`endif

endmodule
